/* hdl/gps_pkg.sv */
// shared types, widths, register codes and rounding helper for the gravity source unit
`timescale 1ns / 1ps

package gps_pkg;

    // fixed point format: signed Q24.24 in 48 bits
    localparam int VW = 48;
    localparam int FW = 24;
    localparam int DW = VW - 1;            // unsigned density and time step
    localparam int PW = 2 * VW;            // full product
    localparam int SW = PW + 2;            // sum of three products

    // operand split for the partial product multiplier
    localparam int ML_W = VW / 2;
    localparam int MU_W = VW - ML_W;
    localparam int MX_W = MU_W + ML_W + 1;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ENABLE = 2'd2;

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_MOM_DOT_G = 3'd1;
    localparam logic [MODE_W-1:0] MODE_KINETIC   = 3'd3;

    typedef struct packed {
        logic [DW-1:0]        density;
        logic signed [VW-1:0] mom_x;
        logic signed [VW-1:0] mom_y;
        logic signed [VW-1:0] mom_z;
        logic signed [VW-1:0] accel_x;
        logic signed [VW-1:0] accel_y;
        logic signed [VW-1:0] accel_z;
    } cell_t;

    typedef struct packed {
        logic signed [VW-1:0] src_mom_x;
        logic signed [VW-1:0] src_mom_y;
        logic signed [VW-1:0] src_mom_z;
        logic signed [VW-1:0] src_energy;
        logic                 saturated;
    } src_t;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 clip;
    } sat_t;

    // round half up, arithmetic shift by s, clip to the value range
    function automatic sat_t rnd_sat(input logic signed [SW-1:0] w, input int s);
        logic signed [SW:0] half;
        logic signed [SW:0] q;
        sat_t               r;
        half = '0;
        half[s-1] = 1'b1;
        q = ((SW+1)'(w) + half) >>> s;
        if (q[SW:VW-1] == '0 || q[SW:VW-1] == '1)
        begin
            r.value = q[VW-1:0];
            r.clip  = 1'b0;
        end
        else
        begin
            r.value = q[SW] ? VMIN : VMAX;
            r.clip  = 1'b1;
        end
        return r;
    endfunction

endpackage

/* hdl/gps_mul.sv */
// two stage signed multiplier built from half width partial products
`timescale 1ns / 1ps

module gps_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [gps_pkg::VW-1:0] a,
    input  logic signed [gps_pkg::VW-1:0] b,
    output logic signed [gps_pkg::PW-1:0] p
);
    import gps_pkg::*;

    logic signed [MU_W-1:0]   ah, bh;
    logic [ML_W-1:0]          al, bl;

    logic signed [2*MU_W-1:0] hh_next, hh_reg;
    logic signed [MX_W-1:0]   hl_next, hl_reg;
    logic signed [MX_W-1:0]   lh_next, lh_reg;
    logic [2*ML_W-1:0]        ll_next, ll_reg;
    logic signed [PW-1:0]     mid;
    logic signed [PW-1:0]     p_next, p_reg;

    assign ah = a[VW-1:ML_W];
    assign bh = b[VW-1:ML_W];
    assign al = a[ML_W-1:0];
    assign bl = b[ML_W-1:0];

    always_comb
    begin
        hh_next = (2*MU_W)'(ah) * (2*MU_W)'(bh);
        hl_next = MX_W'(ah) * MX_W'($signed({1'b0, bl}));
        lh_next = MX_W'($signed({1'b0, al})) * MX_W'(bh);
        ll_next = (2*ML_W)'(al) * (2*ML_W)'(bl);
    end

    // high and low products do not overlap, the cross terms land in the middle
    always_comb
    begin
        mid    = PW'(hl_reg) + PW'(lh_reg);
        p_next = $signed({hh_reg, ll_reg}) + (mid <<< ML_W);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* hdl/gravity_predictor_source_unit.sv */
// gravity source unit: momentum source rho*g and energy source per cell
// throughput: one request per cycle unless a result is stalled; the mode 3 chain gs -> rho*gs -> dt*r -> dt*t2
// runs four two-stage 48x48 multipliers in series, which sets the depth
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset clears the valid bits and loads time_step 0, energy_mode 1, gravity_enable 1
`timescale 1ns / 1ps

module gravity_predictor_source_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cell_valid,
    output logic                             cell_ready,
    input  gps_pkg::cell_t                   cell_data,
    output logic                             src_valid,
    input  logic                             src_ready,
    output gps_pkg::src_t                    src_data,
    input  logic                             cfg_we,
    input  logic [gps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gps_pkg::DW-1:0]           cfg_data
);
    import gps_pkg::*;

    localparam int NSTAGE = 14;
    localparam int RHO_N  = 4;
    localparam int SIDE_N = 10;
    localparam int EXT_N  = 7;

    typedef struct packed {
        logic [2:0][VW-1:0]   srcm;
        logic signed [VW-1:0] d;
        logic                 clip;
        logic                 gs_clip;
    } side_t;

    typedef struct packed {
        logic signed [VW-1:0] t1;
        logic                 clip;
    } ext_t;

    // configuration
    logic [DW-1:0]     time_step_reg, time_step_next;
    logic [MODE_W-1:0] energy_mode_reg, energy_mode_next;
    logic              gravity_enable_reg, gravity_enable_next;

    logic              en;
    logic [NSTAGE-1:0] vld_reg, vld_next;

    logic signed [VW-1:0] rho_in;
    logic signed [VW-1:0] dt_s;
    logic signed [VW-1:0] mom_in [3];
    logic signed [VW-1:0] acc_in [3];
    logic signed [PW-1:0] prod_rg [3];
    logic signed [PW-1:0] prod_mg [3];
    logic signed [PW-1:0] prod_gg [3];
    logic signed [PW-1:0] prod_r, prod_t1, prod_t2, prod_t3;

    logic signed [VW-1:0] rho_reg [RHO_N];
    logic signed [VW-1:0] rho_next [RHO_N];

    logic signed [PW-1:0] mom_prod_reg [3];
    logic signed [PW-1:0] mom_prod_next [3];
    logic signed [SW-1:0] dot_reg, dot_next;
    logic signed [SW-1:0] gg_reg, gg_next;

    sat_t                 sm [3];
    sat_t                 dsat, gsat, rsat, t1sat, t2sat, t3sat;
    logic signed [VW-1:0] gs_reg, gs_next;
    side_t                side_reg [SIDE_N];
    side_t                side_next [SIDE_N];

    logic signed [VW-1:0] r_reg, r_next;
    logic signed [VW-1:0] t2_reg, t2_next;
    logic signed [VW-1:0] t3_reg, t3_next;
    ext_t                 ext_reg [EXT_N];
    ext_t                 ext_next [EXT_N];

    logic signed [VW:0]   fsum;
    logic                 fclip;
    logic signed [VW-1:0] fval;
    logic                 kinetic;
    src_t                 out_reg, out_next;

    // configuration port
    always_comb
    begin
        time_step_next      = time_step_reg;
        energy_mode_next    = energy_mode_reg;
        gravity_enable_next = gravity_enable_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIME_STEP:      time_step_next      = cfg_data;
                CFG_ENERGY_MODE:    energy_mode_next    = cfg_data[MODE_W-1:0];
                CFG_GRAVITY_ENABLE: gravity_enable_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg      <= '0;
            energy_mode_reg    <= MODE_MOM_DOT_G;
            gravity_enable_reg <= 1'b1;
        end
        else
        begin
            time_step_reg      <= time_step_next;
            energy_mode_reg    <= energy_mode_next;
            gravity_enable_reg <= gravity_enable_next;
        end
    end

    // whole pipeline advances unless the output register holds an untaken result
    assign en         = !vld_reg[NSTAGE-1] || src_ready;
    assign cell_ready = en;
    assign vld_next   = {vld_reg[NSTAGE-2:0], cell_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // operand lanes
    assign rho_in    = $signed({1'b0, cell_data.density});
    assign dt_s      = $signed({1'b0, time_step_reg});
    assign mom_in[0] = cell_data.mom_x;
    assign mom_in[1] = cell_data.mom_y;
    assign mom_in[2] = cell_data.mom_z;
    assign acc_in[0] = cell_data.accel_x;
    assign acc_in[1] = cell_data.accel_y;
    assign acc_in[2] = cell_data.accel_z;

    for (genvar n = 0; n < 3; n++)
    begin : g_lane
        gps_mul u_rg (.clk(clk), .en(en), .a(rho_in),    .b(acc_in[n]), .p(prod_rg[n]));
        gps_mul u_mg (.clk(clk), .en(en), .a(mom_in[n]), .b(acc_in[n]), .p(prod_mg[n]));
        gps_mul u_gg (.clk(clk), .en(en), .a(acc_in[n]), .b(acc_in[n]), .p(prod_gg[n]));
    end

    // density follows the first products to meet the scaled g.g
    always_comb
    begin
        rho_next[0] = rho_in;
        for (int i = 1; i < RHO_N; i++)
            rho_next[i] = rho_reg[i-1];
    end

    // dot product sums
    always_comb
    begin
        for (int n = 0; n < 3; n++)
            mom_prod_next[n] = prod_rg[n];
        dot_next = SW'(prod_mg[0]) + SW'(prod_mg[1]) + SW'(prod_mg[2]);
        gg_next  = SW'(prod_gg[0]) + SW'(prod_gg[1]) + SW'(prod_gg[2]);
    end

    // scale momentum sources, m.g and g.g
    always_comb
    begin
        for (int n = 0; n < 3; n++)
            sm[n] = rnd_sat(SW'(mom_prod_reg[n]), FW);
        dsat = rnd_sat(dot_reg, FW);
        gsat = rnd_sat(gg_reg, FW);
        gs_next = gsat.value;
        for (int n = 0; n < 3; n++)
            side_next[0].srcm[n] = sm[n].value;
        side_next[0].d       = dsat.value;
        side_next[0].clip    = sm[0].clip | sm[1].clip | sm[2].clip | dsat.clip;
        side_next[0].gs_clip = gsat.clip;
        for (int i = 1; i < SIDE_N; i++)
            side_next[i] = side_reg[i-1];
    end

    gps_mul u_r  (.clk(clk), .en(en), .a(rho_reg[RHO_N-1]), .b(gs_reg),        .p(prod_r));
    gps_mul u_t1 (.clk(clk), .en(en), .a(dt_s),             .b(side_reg[0].d), .p(prod_t1));
    gps_mul u_t2 (.clk(clk), .en(en), .a(dt_s),             .b(r_reg),         .p(prod_t2));
    gps_mul u_t3 (.clk(clk), .en(en), .a(dt_s),             .b(t2_reg),        .p(prod_t3));

    // kinetic energy chain, clip flags gathered along the way
    always_comb
    begin
        rsat  = rnd_sat(SW'(prod_r), FW);
        t1sat = rnd_sat(SW'(prod_t1), FW);
        t2sat = rnd_sat(SW'(prod_t2), FW);
        t3sat = rnd_sat(SW'(prod_t3), FW + 1);
        r_next  = rsat.value;
        t2_next = t2sat.value;
        t3_next = t3sat.value;
        ext_next[0].t1   = t1sat.value;
        ext_next[0].clip = side_reg[2].gs_clip | rsat.clip | t1sat.clip;
        for (int i = 1; i < EXT_N; i++)
            ext_next[i] = ext_reg[i-1];
        ext_next[3].clip = ext_reg[2].clip | t2sat.clip;
        ext_next[6].clip = ext_reg[5].clip | t3sat.clip;
    end

    // final energy sum and output select
    always_comb
    begin
        kinetic = (energy_mode_reg == MODE_KINETIC);
        fsum    = (VW+1)'(ext_reg[EXT_N-1].t1) + (VW+1)'(t3_reg);
        fclip   = (fsum[VW] != fsum[VW-1]);
        fval    = fclip ? (fsum[VW] ? VMIN : VMAX) : fsum[VW-1:0];
        out_next = '0;
        if (gravity_enable_reg)
        begin
            out_next.src_mom_x  = side_reg[SIDE_N-1].srcm[0];
            out_next.src_mom_y  = side_reg[SIDE_N-1].srcm[1];
            out_next.src_mom_z  = side_reg[SIDE_N-1].srcm[2];
            out_next.src_energy = kinetic ? fval : side_reg[SIDE_N-1].d;
            out_next.saturated  = side_reg[SIDE_N-1].clip
                                  | (kinetic & (ext_reg[EXT_N-1].clip | fclip));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RHO_N; i++)
                rho_reg[i] <= rho_next[i];
            for (int n = 0; n < 3; n++)
                mom_prod_reg[n] <= mom_prod_next[n];
            dot_reg <= dot_next;
            gg_reg  <= gg_next;
            gs_reg  <= gs_next;
            for (int i = 0; i < SIDE_N; i++)
                side_reg[i] <= side_next[i];
            r_reg  <= r_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            for (int i = 0; i < EXT_N; i++)
                ext_reg[i] <= ext_next[i];
            out_reg <= out_next;
        end
    end

    assign src_valid = vld_reg[NSTAGE-1];
    assign src_data  = out_reg;

    // disabled gravity gives an all-zero result
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !gravity_enable_reg |-> src_data == '0)
        else $error("nonzero result with gravity disabled");

    // outside mode 3 a clip always leaves a field at a range limit
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_data.saturated && energy_mode_reg != MODE_KINETIC |->
            src_data.src_mom_x == VMAX || src_data.src_mom_x == VMIN ||
            src_data.src_mom_y == VMAX || src_data.src_mom_y == VMIN ||
            src_data.src_mom_z == VMAX || src_data.src_mom_z == VMIN ||
            src_data.src_energy == VMAX || src_data.src_energy == VMIN)
        else $error("saturated flag without a clipped field");

    // zero time step makes the kinetic energy change vanish
    a_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && gravity_enable_reg && energy_mode_reg == MODE_KINETIC
            && time_step_reg == '0 |-> src_data.src_energy == '0)
        else $error("nonzero energy source with zero time step");

    // a new result only follows a valid item in the stage before
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(src_valid) |-> $past(vld_reg[NSTAGE-2]))
        else $error("result appeared without a request behind it");

endmodule
